/* sv/mdq_pkg.sv */
package mdq_pkg;

  // command codes carried in the cmd field
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_READ       = 3'd2,
    CMD_REMOVE     = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_e;

  // status codes carried in the status field
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  // what an entry cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_TAKE_PREV = 2'd2,
    CELL_TAKE_NEXT = 2'd3
  } cell_op_e;

  localparam int MSG_BITS    = 32;
  localparam int POS_BITS    = 8;
  localparam int COUNT_BITS  = 5;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [MSG_BITS-1:0] msg_in;
    logic [POS_BITS-1:0] position;
  } cmd_word_t;

  typedef struct packed {
    logic [MSG_BITS-1:0]   msg_out;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] entry_count;
  } rsp_word_t;

endpackage

/* sv/message_deque_indexed_remove_core.sv */
// message deque with insert at front, append, read and remove at any position, and clear
// response: a command's response is registered when the command is accepted
// throughput: one command per cycle while the response side does not stall; the entry
//   cells all shift by one place together, and the response register frees as soon as it is taken
// reset: synchronous; count and response valid clear, entry cells keep contents
module message_deque_indexed_remove_core #(
  parameter int DEPTH     = 16,
  parameter int MSG_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  mdq_pkg::cmd_word_t cmd_word,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output mdq_pkg::rsp_word_t rsp_word
);
  import mdq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [CNT_W-1:0]     occ;
  logic [CNT_W-1:0]     occ_next;
  logic                 accept;
  logic                 front_en;
  logic                 back_en;
  logic                 remove_en;
  logic                 take_msg;
  logic                 pos_ok;
  logic [1:0]           status;
  logic [POS_BITS:0]    pos_x;
  logic [POS_BITS:0]    occ_x;
  logic [CNT_W+POS_BITS:0] occ_wide;
  logic [MSG_WIDTH-1:0] new_word;
  logic [MSG_WIDTH-1:0] rd_word;
  logic [MSG_WIDTH+MSG_BITS-1:0] in_wide;
  logic [MSG_WIDTH+MSG_BITS-1:0] out_wide;
  logic [CNT_W+COUNT_BITS-1:0]   cnt_wide;
  rsp_word_t            rsp_next;
  logic [MSG_WIDTH-1:0] cell_word [DEPTH];
  cell_op_e             cell_op   [DEPTH];

  // handshake: the response register parts the two sides
  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  // message kept to its low MSG_WIDTH bits
  assign in_wide  = {{MSG_WIDTH{1'b0}}, cmd_word.msg_in};
  assign new_word = in_wide[MSG_WIDTH-1:0];

  // position check against the current count
  assign pos_x    = {1'b0, cmd_word.position};
  assign occ_wide = {{(POS_BITS + 1){1'b0}}, occ};
  assign occ_x    = occ_wide[POS_BITS:0];
  assign pos_ok   = pos_x < occ_x;

  // read port over the cells
  assign rd_word = cell_word[cmd_word.position[IDX_W-1:0]];

  // command decode
  always_comb begin
    occ_next  = occ;
    status    = ST_DONE;
    front_en  = 1'b0;
    back_en   = 1'b0;
    remove_en = 1'b0;
    take_msg  = 1'b0;
    unique case (cmd_word.cmd)
      CMD_PUSH_FRONT: begin
        if (occ == CNT_W'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          front_en = 1'b1;
          occ_next = occ + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (occ == CNT_W'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          back_en  = 1'b1;
          occ_next = occ + CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_ok) begin
          take_msg = 1'b1;
        end else begin
          status = ST_ABSENT;
        end
      end
      CMD_REMOVE: begin
        if (pos_ok) begin
          take_msg  = 1'b1;
          remove_en = 1'b1;
          occ_next  = occ - CNT_W'(1);
        end else begin
          status = ST_ABSENT;
        end
      end
      CMD_CLEAR: begin
        occ_next = '0;
      end
      default: begin
      end
    endcase
  end

  // response word
  assign out_wide = {{MSG_BITS{1'b0}}, (take_msg ? rd_word : {MSG_WIDTH{1'b0}})};
  assign cnt_wide = {{COUNT_BITS{1'b0}}, occ_next};
  always_comb begin
    rsp_next.msg_out     = out_wide[MSG_BITS-1:0];
    rsp_next.status      = status;
    rsp_next.entry_count = cnt_wide[COUNT_BITS-1:0];
  end

  // chain of entry cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [MSG_WIDTH-1:0] prev_word;
    logic [MSG_WIDTH-1:0] next_word;

    if (i == 0) begin : g_first
      assign prev_word = new_word;
    end else begin : g_mid_prev
      assign prev_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_word = cell_word[i];
    end else begin : g_mid_next
      assign next_word = cell_word[i+1];
    end

    // shift toward the back on front insert, toward the front on remove
    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (accept && front_en) begin
        if (i == 0) begin
          cell_op[i] = CELL_LOAD;
        end else if (CNT_W'(i) <= occ) begin
          cell_op[i] = CELL_TAKE_PREV;
        end
      end else if (accept && back_en && (CNT_W'(i) == occ)) begin
        cell_op[i] = CELL_LOAD;
      end else if (accept && remove_en && ((POS_BITS + 1)'(i) >= pos_x) &&
                   (CNT_W'(i + 1) < occ)) begin
        cell_op[i] = CELL_TAKE_NEXT;
      end
    end

    mdq_cell #(
      .MSG_WIDTH(MSG_WIDTH)
    ) u_cell (
      .clk      (clk),
      .op       (cell_op[i]),
      .new_word (new_word),
      .prev_word(prev_word),
      .next_word(next_word),
      .word     (cell_word[i])
    );
  end

  // count and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else if (accept) begin
      occ       <= occ_next;
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_word <= rsp_next;
    end
  end

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_word.entry_count == cnt_wide[COUNT_BITS-1:0] ||
                  rsp_word.entry_count == occ_wide[COUNT_BITS-1:0])
    else $error("response count differs from stored count");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_word.status != ST_DONE) |-> rsp_word.msg_out == '0)
    else $error("refused command returned a message");

  a_accept_rsp: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted command gave no response");

endmodule

/* sv/mdq_cell.sv */
module mdq_cell #(
  parameter int MSG_WIDTH = 32
) (
  input  logic                 clk,
  input  mdq_pkg::cell_op_e    op,
  input  logic [MSG_WIDTH-1:0] new_word,
  input  logic [MSG_WIDTH-1:0] prev_word,
  input  logic [MSG_WIDTH-1:0] next_word,
  output logic [MSG_WIDTH-1:0] word
);
  import mdq_pkg::*;

  // one stored entry, loaded from the new word or a neighbor
  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:      word <= new_word;
      CELL_TAKE_PREV: word <= prev_word;
      CELL_TAKE_NEXT: word <= next_word;
      default:        word <= word;
    endcase
  end

endmodule

/* tb/sv/mdq_deque_checker.sv */
`timescale 1ns / 1ps

module mdq_deque_checker #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_stall,
  input  mdq_pkg::cmd_word_t cmd_word,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  mdq_pkg::rsp_word_t rsp_word,
  output int                 pending,
  output int                 errors
);
  import mdq_pkg::*;

  // keep the log readable when the block is badly broken
  localparam int PRINT_LIMIT = 100;

  // shadow copy of the deque contents
  logic [MSG_BITS-1:0] held_msgs [DEPTH];
  int unsigned         held_count;
  rsp_word_t           expected_rsp_q [$];

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_LIMIT)
      $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  // apply one command word to the shadow deque, return the response it causes
  function automatic rsp_word_t apply_command(input cmd_word_t w);
    rsp_word_t   r;
    int unsigned pos;
    int unsigned i;
    r   = '0;
    pos = w.position;
    case (w.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (w.cmd == CMD_PUSH_FRONT) begin
          for (i = held_count; i > 0; i--)
            held_msgs[i] = held_msgs[i-1];
          held_msgs[0] = w.msg_in;
          held_count++;
        end else begin
          held_msgs[held_count] = w.msg_in;
          held_count++;
        end
      end
      CMD_READ, CMD_REMOVE: begin
        if (pos >= held_count) begin
          r.status = ST_ABSENT;
        end else begin
          r.msg_out = held_msgs[pos];
          if (w.cmd == CMD_REMOVE) begin
            for (i = pos; i + 1 < held_count; i++)
              held_msgs[i] = held_msgs[i+1];
            held_count--;
          end
        end
      end
      CMD_CLEAR: held_count = 0;
      default: ;
    endcase
    r.entry_count = COUNT_BITS'(held_count);
    return r;
  endfunction

  // compare taken responses, then queue the expectation for a taken command
  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      held_count = 0;
      errors     = 0;
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response %h with nothing outstanding", rsp_word));
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_word.msg_out !== want.msg_out)
            report_mismatch($sformatf("msg_out %h, expected %h",
                                      rsp_word.msg_out, want.msg_out));
          if (rsp_word.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_word.status, want.status));
          if (rsp_word.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      rsp_word.entry_count, want.entry_count));
        end
      end
      if (cmd_valid && !cmd_stall)
        expected_rsp_q.push_back(apply_command(cmd_word));
    end
    pending = expected_rsp_q.size();
  end

endmodule

/* tb/sv/message_deque_indexed_remove_core_tb.sv */
`timescale 1ns / 1ps

module message_deque_indexed_remove_core_tb;
  import mdq_pkg::*;

  localparam int DEPTH            = 16;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int RANDOM_BLOCKS    = 16;
  localparam int BLOCK_WORDS      = 100;
  localparam int HOLD_BLOCK       = 5;
  localparam int DRAIN_BLOCK      = 9;
  localparam int QUIET_FROM_BLOCK = 14;
  localparam int TAIL_CYCLES      = 10;

  // command codes the block treats as no-ops
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_word_t cmd_word;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_word_t rsp_word;

  int        pending;
  int        errors;
  bit        idle_on;
  bit        hold_rsp;

  message_deque_indexed_remove_core #(
    .DEPTH    (DEPTH),
    .MSG_WIDTH(MSG_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_word (cmd_word),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_word (rsp_word)
  );

  mdq_deque_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_word (cmd_word),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_word (rsp_word),
    .pending  (pending),
    .errors   (errors)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic cmd_word_t make_word(input logic [2:0] op,
                                          input logic [MSG_BITS-1:0] msg,
                                          input logic [POS_BITS-1:0] pos);
    cmd_word_t w;
    w.cmd      = op;
    w.msg_in   = msg;
    w.position = pos;
    return w;
  endfunction

  // random command; fill-leaning mixes push more, drain-leaning ones remove more
  function automatic cmd_word_t random_word(input bit fill_lean);
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  pos;
    pick = $urandom_range(0, 99);
    if (fill_lean) begin
      if (pick < 30)      op = CMD_PUSH_FRONT;
      else if (pick < 60) op = CMD_PUSH_BACK;
      else if (pick < 75) op = CMD_READ;
      else if (pick < 95) op = CMD_REMOVE;
      else if (pick < 97) op = CMD_CLEAR;
      else                op = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    end else begin
      if (pick < 15)      op = CMD_PUSH_FRONT;
      else if (pick < 30) op = CMD_PUSH_BACK;
      else if (pick < 50) op = CMD_READ;
      else if (pick < 95) op = CMD_REMOVE;
      else if (pick < 97) op = CMD_CLEAR;
      else                op = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    end
    // mostly positions near the live range, sometimes anywhere
    if ($urandom_range(0, 99) < 85) pos = 8'($urandom_range(0, DEPTH));
    else                            pos = 8'($urandom_range(0, 255));
    return make_word(op, $urandom(), pos);
  endfunction

  // offer one word, hold it until taken, then maybe go idle for a burst
  task automatic send_word(input cmd_word_t w);
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // response side: random stall bursts, or one long hold on request
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        hold_rsp = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int blk;
    int n;
    int op;
    bit fill_lean;
    cmd_valid = 1'b0;
    cmd_word  = '0;
    idle_on   = 1'b0;
    hold_rsp  = 1'b0;
    rst       = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty store: nothing to read or remove
    send_word(make_word(CMD_READ, 32'h0, 8'd0));
    send_word(make_word(CMD_REMOVE, 32'hFFFF_FFFF, 8'd255));
    // spare codes do nothing
    for (op = CMD_UNUSED_FIRST; op <= CMD_UNUSED_LAST; op++)
      send_word(make_word(3'(op), $urandom(), 8'($urandom())));
    // fill up from both ends, extreme words first
    send_word(make_word(CMD_PUSH_FRONT, 32'h0000_0000, 8'd0));
    send_word(make_word(CMD_PUSH_BACK, 32'hFFFF_FFFF, 8'd255));
    for (n = 2; n < DEPTH; n++)
      send_word(make_word(n % 2 ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom(), 8'(n)));
    // full store refuses both inserts
    send_word(make_word(CMD_PUSH_FRONT, 32'h1234_5678, 8'd0));
    send_word(make_word(CMD_PUSH_BACK, 32'h8765_4321, 8'd0));
    // last entry, one past it, then remove last, front and middle
    send_word(make_word(CMD_READ, 32'h0, 8'(DEPTH - 1)));
    send_word(make_word(CMD_READ, 32'h0, 8'(DEPTH)));
    send_word(make_word(CMD_REMOVE, 32'h0, 8'(DEPTH - 1)));
    send_word(make_word(CMD_REMOVE, 32'h0, 8'd0));
    send_word(make_word(CMD_REMOVE, 32'h0, 8'd7));
    // clear, then nothing is left
    send_word(make_word(CMD_CLEAR, 32'h0, 8'd0));
    send_word(make_word(CMD_READ, 32'h0, 8'd0));

    // random blocks with changing idle and fill behavior
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      fill_lean = $urandom_range(0, 1);
      if (blk >= QUIET_FROM_BLOCK || blk == HOLD_BLOCK) idle_on = 1'b0;
      else                                              idle_on = ($urandom_range(0, 3) != 0);
      if (blk == HOLD_BLOCK) begin
        // response side holds off while commands keep coming
        fill_lean = 1'b1;
        hold_rsp  = 1'b1;
      end
      for (n = 0; n < BLOCK_WORDS; n++)
        send_word(random_word(fill_lean));
      if (blk == DRAIN_BLOCK) begin
        // stop and let every response come back
        cmd_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
    end

    // wind down
    cmd_valid <= 1'b0;
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
